@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the set-of-stacks RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define SOSP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define SOSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sosp_pkg.sv @@
// ----------------------------------------------------------------------------
// sosp_pkg
// Shared codes and types for the set of stacks with pop-at.
// ----------------------------------------------------------------------------
package sosp_pkg;

    localparam int PLATES_W = 7;
    localparam logic [PLATES_W-1:0] PLATES_RESET = 7'd3;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int SIDX_W   = 6;
    localparam int OUTVAL_W = 32;
    localparam int OUTCNT_W = 7;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_PLATES = 2'd0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_POP_AT  = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADIDX = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Per-cell move: keep, take the newer neighbor, take the older neighbor.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_TAKE_NEWER = 2'd1,
        CELL_TAKE_OLDER = 2'd2
    } cell_ctl_t;

    // Layout bookkeeping request for one item.
    typedef struct packed {
        logic grow;
        logic shrink;
    } layout_step_t;

endpackage

@@ hw/rtl/sosp_cell.sv @@
// ----------------------------------------------------------------------------
// sosp_cell
// One storage cell of the value chain; loads from either neighbor.
// ----------------------------------------------------------------------------
module sosp_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  sosp_pkg::cell_ctl_t           ctl_i,
    input  logic signed [VALUE_WIDTH-1:0] newer_i,
    input  logic signed [VALUE_WIDTH-1:0] older_i,
    output logic signed [VALUE_WIDTH-1:0] value_o
);

    logic signed [VALUE_WIDTH-1:0] value_reg;

    always_ff @(posedge aclk) begin
        unique case (ctl_i)
            sosp_pkg::CELL_TAKE_NEWER: value_reg <= newer_i;
            sosp_pkg::CELL_TAKE_OLDER: value_reg <= older_i;
            default:                   value_reg <= value_reg;
        endcase
    end

    assign value_o = value_reg;

endmodule

@@ hw/rtl/sosp_layout.sv @@
// ----------------------------------------------------------------------------
// sosp_layout
// Tracks last sub-stack index and fill; rebuilds them by restoring
// division after a capacity change, or clears them if the store is empty.
// ----------------------------------------------------------------------------
module sosp_layout #(
    parameter int CNT_W = 7,
    parameter int IDX_W = 6
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start_i,
    input  logic [CNT_W-1:0]               count_i,
    input  logic [sosp_pkg::PLATES_W-1:0]  cap_i,
    input  sosp_pkg::layout_step_t         step_i,
    output logic [IDX_W-1:0]               idx_o,
    output logic [IDX_W-1:0]               idx_next_o,
    output logic                           busy_o
);

    localparam int FW     = sosp_pkg::PLATES_W;
    localparam int STEP_W = $clog2(CNT_W + 1);

    typedef enum logic [1:0] {
        LY_IDLE = 2'b01,
        LY_DIV  = 2'b10
    } ly_state_t;

    ly_state_t         state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]  dsh_reg, dsh_next;
    logic [FW-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [FW:0]       rem_sh;
    logic              rem_ge;
    logic [FW-1:0]     rem_new;
    logic [CNT_W-1:0]  quo_new;

    // one quotient bit per cycle
    always_comb begin
        rem_sh  = {rem_reg, dsh_reg[CNT_W-1]};
        rem_ge  = rem_sh >= {1'b0, cap_i};
        rem_new = rem_ge ? FW'(rem_sh - {1'b0, cap_i}) : rem_sh[FW-1:0];
        quo_new = {quo_reg[CNT_W-2:0], rem_ge};
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        dsh_next   = dsh_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        unique case (state_reg)
            LY_IDLE: begin
                if (start_i) begin
                    if (count_i == '0) begin
                        idx_next  = '0;
                        fill_next = '0;
                    end else begin
                        dsh_next   = count_i - CNT_W'(1);
                        rem_next   = '0;
                        quo_next   = '0;
                        step_next  = STEP_W'(CNT_W);
                        state_next = LY_DIV;
                    end
                end else if (step_i.grow) begin
                    if (fill_reg == '0) begin
                        idx_next  = '0;
                        fill_next = FW'(1);
                    end else if (fill_reg == cap_i) begin
                        idx_next  = idx_reg + IDX_W'(1);
                        fill_next = FW'(1);
                    end else begin
                        fill_next = fill_reg + FW'(1);
                    end
                end else if (step_i.shrink) begin
                    if (fill_reg == FW'(1)) begin
                        if (idx_reg == '0) begin
                            fill_next = '0;
                        end else begin
                            idx_next  = idx_reg - IDX_W'(1);
                            fill_next = cap_i;
                        end
                    end else begin
                        fill_next = fill_reg - FW'(1);
                    end
                end
            end
            LY_DIV: begin
                dsh_next  = {dsh_reg[CNT_W-2:0], 1'b0};
                rem_next  = rem_new;
                quo_next  = quo_new;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    idx_next   = IDX_W'(quo_new);
                    fill_next  = rem_new + FW'(1);
                    state_next = LY_IDLE;
                end
            end
            default: state_next = LY_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LY_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dsh_reg <= dsh_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign idx_o      = idx_reg;
    assign idx_next_o = idx_next;
    assign busy_o     = (state_reg == LY_DIV);

endmodule

@@ hw/rtl/set_of_stacks_with_pop_at_top.sv @@
// Set of stacks with pop-at: one store of STORE_DEPTH values viewed as
// sub-stacks of plates_per_stack values each (0 is taken as 1), all full
// except the last. Push, pop, pop-at and read-top each give one result item
// holding the newest value (0 when empty), the count, the last sub-stack
// index and a status. The store is a chain of cells kept newest-first, so
// every operation is a single neighbor shift: an item is taken each cycle
// unless a layout rebuild or a held result stalls it, and its result
// appears on the m_ side the next cycle, while the output register lets the
// next item in as the current result is taken. A write of plates_per_stack
// starts a restoring division of the count by the new capacity that rebuilds
// the sub-stack layout; while the store holds values, s_ready stays low until
// the division is done, and not at all when the store is empty.
// The register sits at byte address 0 of the APB-style port.
// ----------------------------------------------------------------------------
// set_of_stacks_with_pop_at_top
// Top level: APB register, item handshake, cell chain and layout tracking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_of_stacks_with_pop_at_top #(
    parameter int STORE_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sosp_pkg::PADDR_W-1:0]         paddr,
    input  logic [sosp_pkg::PDATA_W-1:0]         pwdata,
    output logic [sosp_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready,
    // input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [sosp_pkg::ACTION_W-1:0]        s_action,
    input  logic signed [31:0]                   s_value,
    input  logic [sosp_pkg::SIDX_W-1:0]          s_stack_index,
    // result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sosp_pkg::OUTVAL_W-1:0] m_top_value,
    output logic [sosp_pkg::STATUS_W-1:0]        m_status,
    output logic [sosp_pkg::OUTCNT_W-1:0]        m_item_count,
    output logic [sosp_pkg::SIDX_W-1:0]          m_current_stack
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int PW    = sosp_pkg::PLATES_W;
    // wide enough for (index+1)*capacity and for the count
    localparam int EW    = (CNT_W > 13) ? CNT_W : 13;
    localparam int CW    = (IDX_W > sosp_pkg::SIDX_W) ? IDX_W : sosp_pkg::SIDX_W;

    // ---------------- configuration register ----------------
    logic [PW-1:0] plates_reg;
    logic [PW-1:0] cap;
    logic          cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == sosp_pkg::ADDR_PLATES);
    assign pready = 1'b1;
    assign prdata = (paddr == sosp_pkg::ADDR_PLATES) ? sosp_pkg::PDATA_W'(plates_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plates_reg <= sosp_pkg::PLATES_RESET;
        end else if (cfg_wr) begin
            plates_reg <= pwdata[PW-1:0];
        end
    end

    // zero capacity behaves as one
    assign cap = (plates_reg == '0) ? PW'(1) : plates_reg;

    // ---------------- state ----------------
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_cur, idx_next;
    logic             layout_busy;
    logic             s_accept;

    logic                    m_valid_reg;
    logic signed [sosp_pkg::OUTVAL_W-1:0] m_top_value_reg;
    sosp_pkg::status_t       m_status_reg;
    logic [sosp_pkg::OUTCNT_W-1:0] m_item_count_reg;
    logic [sosp_pkg::SIDX_W-1:0]   m_current_stack_reg;

    // One item at a time through the chain; held back only by a full output
    // register or a layout rebuild.
    assign s_ready  = !layout_busy && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;

    // ---------------- pop-at position ----------------
    // Chain index 0 is the newest value. The sub-stack top removed by
    // pop-at lies at min((index+1)*cap, count) from the bottom, i.e. at
    // count - min(...) from the newest end.
    logic [EW-1:0]    end_pos;
    logic [EW-1:0]    count_ext;
    logic [IDX_W-1:0] cut_pos;
    logic             bad_index;

    always_comb begin
        end_pos   = (EW'(s_stack_index) + EW'(1)) * EW'(cap);
        count_ext = EW'(count_reg);
        cut_pos   = (end_pos >= count_ext) ? '0 : IDX_W'(count_ext - end_pos);
        bad_index = CW'(s_stack_index) > CW'(idx_cur);
    end

    // ---------------- operation decode ----------------
    sosp_pkg::status_t      status_d;
    sosp_pkg::layout_step_t step_d;
    sosp_pkg::layout_step_t step_q;
    sosp_pkg::cell_ctl_t    op_ctl;
    logic                   op_cut;
    sosp_pkg::cell_ctl_t    cell_ctl [STORE_DEPTH];

    always_comb begin
        status_d    = sosp_pkg::ST_OK;
        step_d      = '0;
        count_next  = count_reg;
        op_ctl      = sosp_pkg::CELL_HOLD;
        op_cut      = 1'b0;
        unique case (sosp_pkg::action_t'(s_action))
            sosp_pkg::ACT_PUSH: begin
                if (count_reg == CNT_W'(STORE_DEPTH)) begin
                    status_d = sosp_pkg::ST_FULL;
                end else begin
                    step_d.grow = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    op_ctl      = sosp_pkg::CELL_TAKE_NEWER;
                end
            end
            sosp_pkg::ACT_POP: begin
                if (count_reg == '0) begin
                    status_d = sosp_pkg::ST_EMPTY;
                end else begin
                    step_d.shrink = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                    op_ctl        = sosp_pkg::CELL_TAKE_OLDER;
                end
            end
            sosp_pkg::ACT_POP_AT: begin
                if (bad_index) begin
                    status_d = sosp_pkg::ST_BADIDX;
                end else if (count_reg == '0) begin
                    status_d = sosp_pkg::ST_EMPTY;
                end else begin
                    step_d.shrink = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                    op_ctl        = sosp_pkg::CELL_TAKE_OLDER;
                    op_cut        = 1'b1;
                end
            end
            sosp_pkg::ACT_READ: begin
                if (count_reg == '0) begin
                    status_d = sosp_pkg::ST_EMPTY;
                end
            end
            default: status_d = sosp_pkg::ST_OK;
        endcase
    end

    // per-cell moves; pop-at only shifts the cells at or past the cut
    always_comb begin
        for (int j = 0; j < STORE_DEPTH; j++) begin
            if (!s_accept) begin
                cell_ctl[j] = sosp_pkg::CELL_HOLD;
            end else if (op_cut && (IDX_W'(j) < cut_pos)) begin
                cell_ctl[j] = sosp_pkg::CELL_HOLD;
            end else begin
                cell_ctl[j] = op_ctl;
            end
        end
    end

    assign step_q.grow   = s_accept && step_d.grow;
    assign step_q.shrink = s_accept && step_d.shrink;

    // ---------------- cell chain ----------------
    logic signed [VALUE_WIDTH-1:0] cell_q     [STORE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] cell_newer [STORE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] cell_older [STORE_DEPTH];

    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_newer[g] = VALUE_WIDTH'(s_value);
        end else begin : g_mid
            assign cell_newer[g] = cell_q[g-1];
        end
        if (g == STORE_DEPTH - 1) begin : g_tail
            assign cell_older[g] = cell_q[g];
        end else begin : g_body
            assign cell_older[g] = cell_q[g+1];
        end

        sosp_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .aclk    (aclk),
            .ctl_i   (cell_ctl[g]),
            .newer_i (cell_newer[g]),
            .older_i (cell_older[g]),
            .value_o (cell_q[g])
        );
    end

    // ---------------- layout ----------------
    sosp_layout #(
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_layout (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (cfg_wr),
        .count_i    (count_reg),
        .cap_i      (cap),
        .step_i     (step_q),
        .idx_o      (idx_cur),
        .idx_next_o (idx_next),
        .busy_o     (layout_busy)
    );

    // ---------------- result ----------------
    // newest value after the move, taken from what cell 0 is about to load
    logic signed [VALUE_WIDTH-1:0] head_next;

    always_comb begin
        case (cell_ctl[0])
            sosp_pkg::CELL_TAKE_NEWER: head_next = cell_newer[0];
            sosp_pkg::CELL_TAKE_OLDER: head_next = cell_older[0];
            default:                   head_next = cell_q[0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_top_value_reg     <= (count_next == '0) ? '0
                                   : sosp_pkg::OUTVAL_W'(head_next);
            m_status_reg        <= status_d;
            m_item_count_reg    <= sosp_pkg::OUTCNT_W'(count_next);
            m_current_stack_reg <= sosp_pkg::SIDX_W'(idx_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_top_value     = m_top_value_reg;
    assign m_status        = m_status_reg;
    assign m_item_count    = m_item_count_reg;
    assign m_current_stack = m_current_stack_reg;

    // ---------------- assertions ----------------
    `SOSP_ASSERT_NEXT(a_item_gives_result,
        s_valid && s_ready, m_valid,
        "accepted item produced no result")
    `SOSP_ASSERT_IMPL(a_full_at_depth,
        m_valid && (m_status == sosp_pkg::ST_FULL),
        m_item_count == sosp_pkg::OUTCNT_W'(STORE_DEPTH),
        "full status below depth")
    `SOSP_ASSERT_IMPL(a_empty_reads_zero,
        m_valid && (m_item_count == '0), m_top_value == '0,
        "empty store reported nonzero top")
    `SOSP_ASSERT_IMPL(a_no_item_in_rebuild,
        layout_busy, !s_accept && !step_q.grow && !step_q.shrink,
        "item taken during layout rebuild")

endmodule
